// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file b64c_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define B64C_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the block's own clock and reset.
`define B64C_ASSERT(lbl, prop, msg) \
	`B64C_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// File: rtl/core/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// Types, constants and alphabet helpers for the base64 stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam int         MAX_RES  = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
		logic       err;
	} b64c_res_t;

	// 6-bit value to standard alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26)
			c = 8'h41 + {2'b00, v};
		else if (v < 6'd52)
			c = 8'h61 + {2'b00, v - 6'd26};
		else if (v < 6'd62)
			c = 8'h30 + {2'b00, v - 6'd52};
		else if (v == 6'd62)
			c = 8'h2B;
		else
			c = 8'h2F;
		return c;
	endfunction

	// character to 6-bit value; anything foreign maps to zero
	function automatic logic [5:0] dec_value(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A)
			t = c - 8'h41;
		else if (c >= 8'h61 && c <= 8'h7A)
			t = c - 8'h61 + 8'd26;
		else if (c >= 8'h30 && c <= 8'h39)
			t = c - 8'h30 + 8'd52;
		else if (c == 8'h2B)
			t = 8'd62;
		else if (c == 8'h2F)
			t = 8'd63;
		return t[5:0];
	endfunction

	function automatic b64c_res_t mk_char(input logic [7:0] c);
		b64c_res_t r;
		r.data = c;
		r.has  = 1'b1;
		r.last = 1'b0;
		r.err  = 1'b0;
		return r;
	endfunction

endpackage

// File: rtl/core/base64_stream_codec_top.sv
// Latency: first result of an item is shown the cycle after its request is taken.
// Throughput: one result per cycle while m_tready is high, out of a four-entry
// result register; results per item: encode 1-2, encode flush up to 4, decode 0-2.
// A new request is taken in the cycle the last buffered result leaves.
// Reset: group state and result count cleared (buffer emptied), mode returns to encode.
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// Streaming base64 encoder/decoder, standard alphabet, with mode register.
// ----------------------------------------------------------------------------
module base64_stream_codec_top
	import b64c_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_data,    // [0] decode_mode
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // [7:0] in_byte
	input  logic       s_tlast,     // in_last
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,     // [7:0] out_byte
	output logic       m_tlast,     // out_last
	output logic [1:0] m_tuser      // [0] has_byte, [1] error
);

	logic       mode_q;
	logic [1:0] phase_q;
	logic [5:0] lo_q;
	logic       pad_q;

	b64c_res_t  res_q [MAX_RES];
	logic [2:0] cnt_q;

	b64c_res_t  res_n [MAX_RES];
	logic [2:0] k_n;
	logic [1:0] phase_n;
	logic [5:0] lo_n;
	logic       pad_n;

	logic       take;
	logic       acc;
	logic       cfg_acc;

	logic [5:0] v;
	logic       is_pad;
	logic [7:0] dbyte;
	logic       made;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;

	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tdata  = res_q[0].data;
	assign m_tlast  = res_q[0].last;
	assign m_tuser  = {res_q[0].err, res_q[0].has};

	assign take     = m_tvalid & m_tready;
	assign s_tready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_tready);
	assign acc      = s_tvalid & s_tready;

	assign v      = dec_value(s_tdata);
	assign is_pad = (s_tdata == PAD_CHAR);

	always_comb begin
		for (int i = 0; i < MAX_RES; i++)
			res_n[i] = '0;
		k_n     = 3'd0;
		phase_n = phase_q;
		lo_n    = lo_q;
		pad_n   = pad_q;
		dbyte   = 8'h00;
		made    = 1'b0;

		if (!mode_q) begin
			case (phase_q)
				2'd1: begin
					res_n[0] = mk_char(enc_char({lo_q[1:0], s_tdata[7:4]}));
					lo_n     = {2'b00, s_tdata[3:0]};
					phase_n  = 2'd2;
					if (s_tlast) begin
						res_n[1] = mk_char(enc_char({s_tdata[3:0], 2'b00}));
						res_n[2] = mk_char(PAD_CHAR);
						k_n      = 3'd3;
					end else begin
						k_n = 3'd1;
					end
				end
				2'd2: begin
					res_n[0] = mk_char(enc_char({lo_q[3:0], s_tdata[7:6]}));
					res_n[1] = mk_char(enc_char(s_tdata[5:0]));
					lo_n     = 6'd0;
					phase_n  = 2'd0;
					k_n      = 3'd2;
				end
				default: begin
					// phase 3 cannot occur in encode; treated as a group start
					res_n[0] = mk_char(enc_char(s_tdata[7:2]));
					lo_n     = {4'b0000, s_tdata[1:0]};
					phase_n  = 2'd1;
					if (s_tlast) begin
						res_n[1] = mk_char(enc_char({s_tdata[1:0], 4'b0000}));
						res_n[2] = mk_char(PAD_CHAR);
						res_n[3] = mk_char(PAD_CHAR);
						k_n      = 3'd4;
					end else begin
						k_n = 3'd1;
					end
				end
			endcase
			for (int i = 0; i < MAX_RES; i++)
				res_n[i].last = s_tlast && (k_n == 3'(i + 1));
		end else begin
			case (phase_q)
				2'd0: lo_n = v;
				2'd1: begin
					dbyte = {lo_q, v[5:4]};
					lo_n  = {2'b00, v[3:0]};
				end
				2'd2: begin
					dbyte = {lo_q[3:0], v[5:2]};
					lo_n  = {4'b0000, v[1:0]};
				end
				default: begin
					dbyte = {lo_q[1:0], v};
					lo_n  = 6'd0;
				end
			endcase
			pad_n   = pad_q | is_pad;
			made    = (phase_q != 2'd0) && !pad_n;
			phase_n = phase_q + 2'd1;
			if (phase_n == 2'd0) begin
				lo_n  = 6'd0;
				pad_n = 1'b0;
			end

			if (made) begin
				res_n[0] = mk_char(dbyte);
				k_n      = 3'd1;
			end
			if (s_tlast) begin
				if (phase_n != 2'd0) begin
					// message ends inside a group: trailing error marker
					res_n[k_n[1:0]].last = 1'b1;
					res_n[k_n[1:0]].err  = 1'b1;
					k_n                  = k_n + 3'd1;
				end else if (made) begin
					res_n[0].last = 1'b1;
				end else begin
					res_n[0].last = 1'b1;
					k_n           = 3'd1;
				end
			end
		end

		if (s_tlast) begin
			phase_n = 2'd0;
			lo_n    = 6'd0;
			pad_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			phase_q <= 2'd0;
			lo_q    <= 6'd0;
			pad_q   <= 1'b0;
			cnt_q   <= 3'd0;
		end else begin
			if (cfg_acc) begin
				mode_q  <= cfg_data[0];
				phase_q <= 2'd0;
				lo_q    <= 6'd0;
				pad_q   <= 1'b0;
			end else if (acc) begin
				phase_q <= phase_n;
				lo_q    <= lo_n;
				pad_q   <= pad_n;
			end
			if (acc)
				cnt_q <= k_n;
			else if (take)
				cnt_q <= cnt_q - 3'd1;
		end
	end

	// result buffer: load a fresh group, or shift one out
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < MAX_RES; i++)
				res_q[i] <= res_n[i];
		end else if (take) begin
			for (int i = 0; i < MAX_RES - 1; i++)
				res_q[i] <= res_q[i + 1];
		end
	end

endmodule

// File: rtl/core/b64c_checker.sv
// ----------------------------------------------------------------------------
// b64c_checker
// Port-level checks for the base64 stream codec, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64c_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	// stalled result holds
	`B64C_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	// an empty result only ever closes a message, with zero data
	`B64C_ASSERT(a_empty_last, m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'h00, "empty result not an end marker")

	// error flag only on an empty end marker
	`B64C_ASSERT(a_err_marker, m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0], "error on a data result")

	// with nothing buffered a request is always taken
	`B64C_ASSERT(a_ready_idle, !m_tvalid |-> s_tready, "idle block not ready")

endmodule

bind base64_stream_codec_top b64c_checker u_b64c_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// File: tb/base64_stream_checker.sv
// ----------------------------------------------------------------------------
// base64_stream_checker
// Watches the mode, input and output channels of the base64 codec. It keeps
// its own copy of the group state, works out the characters or bytes that
// each accepted request should give, and compares every output request with
// the oldest one still owed.
// ----------------------------------------------------------------------------
module base64_stream_checker
	import b64c_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [0:0] cfg_data,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	input  logic [1:0] m_tuser,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [8*64-1:0] ALPHA =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic       decoding;
	logic [1:0] grp_pos;
	logic [5:0] carry;
	logic       pad_hit;
	b64c_res_t  owed_results[$];

	function automatic logic [7:0] sym(input logic [5:0] v);
		return ALPHA[8*(63 - int'(v)) +: 8];
	endfunction

	// reverse lookup; anything not in the alphabet stays zero
	function automatic logic [5:0] six_of(input logic [7:0] c);
		logic [5:0] v;
		v = '0;
		for (int i = 0; i < 64; i++)
			if (ALPHA[8*(63 - i) +: 8] == c)
				v = i[5:0];
		return v;
	endfunction

	task automatic owe(input logic [7:0] d, input logic h, input logic l, input logic e);
		b64c_res_t r;
		r.data = d;
		r.has  = h;
		r.last = l;
		r.err  = e;
		owed_results.push_back(r);
	endtask

	task automatic clear_group();
		grp_pos = '0;
		carry   = '0;
		pad_hit = 1'b0;
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic l);
		logic [7:0] ch[4];
		int         k;
		k = 0;
		case (grp_pos)
			2'd1: begin
				ch[0]   = sym({carry[1:0], b[7:4]});
				carry   = {2'b00, b[3:0]};
				grp_pos = 2'd2;
				k       = 1;
			end
			2'd2: begin
				ch[0]   = sym({carry[3:0], b[7:6]});
				ch[1]   = sym(b[5:0]);
				carry   = '0;
				grp_pos = 2'd0;
				k       = 2;
			end
			default: begin
				ch[0]   = sym(b[7:2]);
				carry   = {4'b0000, b[1:0]};
				grp_pos = 2'd1;
				k       = 1;
			end
		endcase
		if (l) begin
			if (grp_pos == 2'd1) begin
				ch[k]     = sym({carry[1:0], 4'b0000});
				ch[k + 1] = PAD_CHAR;
				ch[k + 2] = PAD_CHAR;
				k         = k + 3;
			end else if (grp_pos == 2'd2) begin
				ch[k]     = sym({carry[3:0], 2'b00});
				ch[k + 1] = PAD_CHAR;
				k         = k + 2;
			end
			clear_group();
		end
		for (int i = 0; i < k; i++)
			owe(ch[i], 1'b1, l && (i == k - 1), 1'b0);
	endtask

	task automatic decode_char(input logic [7:0] c, input logic l);
		logic [5:0] v;
		logic [7:0] byt;
		logic       made;
		v    = six_of(c);
		byt  = '0;
		made = 1'b0;
		case (grp_pos)
			2'd0: carry = v;
			2'd1: begin
				byt   = {carry, v[5:4]};
				carry = {2'b00, v[3:0]};
				made  = 1'b1;
			end
			2'd2: begin
				byt   = {carry[3:0], v[5:2]};
				carry = {4'b0000, v[1:0]};
				made  = 1'b1;
			end
			default: begin
				byt   = {carry[1:0], v};
				carry = '0;
				made  = 1'b1;
			end
		endcase
		if (c == PAD_CHAR)
			pad_hit = 1'b1;
		if (pad_hit)
			made = 1'b0;
		grp_pos = grp_pos + 2'd1;
		if (grp_pos == 2'd0) begin
			carry   = '0;
			pad_hit = 1'b0;
		end
		if (!l) begin
			if (made)
				owe(byt, 1'b1, 1'b0, 1'b0);
		end else begin
			// message closing mid-group: byte (if any) then an error marker
			if (grp_pos != 2'd0) begin
				if (made)
					owe(byt, 1'b1, 1'b0, 1'b0);
				owe(8'h00, 1'b0, 1'b1, 1'b1);
			end else if (made) begin
				owe(byt, 1'b1, 1'b1, 1'b0);
			end else begin
				owe(8'h00, 1'b0, 1'b1, 1'b0);
			end
			clear_group();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		b64c_res_t want;
		b64c_res_t got;
		if (!arst_n) begin
			decoding = 1'b0;
			clear_group();
			owed_results.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				decoding = cfg_data[0];
				clear_group();
			end
			if (s_tvalid && s_tready) begin
				if (decoding)
					decode_char(s_tdata, s_tlast);
				else
					encode_byte(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				got.data = m_tdata;
				got.has  = m_tuser[0];
				got.last = m_tlast;
				got.err  = m_tuser[1];
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected output request data=%h has=%b last=%b err=%b",
						$time, got.data, got.has, got.last, got.err);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					if (got.data != want.data || got.has != want.has ||
						got.last != want.last || got.err != want.err) begin
						$display("%0t: expected data=%h has=%b last=%b err=%b, got data=%h has=%b last=%b err=%b",
							$time, want.data, want.has, want.last, want.err,
							got.data, got.has, got.last, got.err);
						fail_count++;
					end
				end
			end
			pending <= owed_results.size();
		end
	end

endmodule

// File: tb/tb_base64_stream_codec_top.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_codec_top
// Drives the base64 codec through encode and decode messages: a directed set
// of edge groups, padding, foreign characters and short endings, then random
// messages under random back-pressure, with the checker doing the comparison.
// ----------------------------------------------------------------------------
module tb_base64_stream_codec_top;
	import b64c_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT        = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 80;
	localparam int SETTLE       = 8;
	localparam logic ENCODE     = 1'b0;
	localparam logic DECODE     = 1'b1;
	localparam logic [8*64-1:0] ALPHA =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [0:0] cfg_data  = '0;
	logic       s_tvalid  = 1'b0;
	logic [7:0] s_tdata   = '0;
	logic       s_tlast   = 1'b0;
	logic       m_tready  = 1'b0;
	logic       cfg_ready;
	logic       s_tready;
	logic       m_tvalid;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;

	int         fails;
	int         pending;
	int         cycle_count   = 0;
	int         items_sent    = 0;
	int         results_taken = 0;
	int         mode_writes   = 0;
	bit         calm          = 1'b0;
	bit         hold_req      = 1'b0;
	logic       cur_mode      = ENCODE;
	logic [7:0] msg_q[$];

	base64_stream_codec_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	base64_stream_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.fail_count (fails),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("timed out after %0d cycles", cycle_count);
		$display("base64_stream_codec_top: mismatch");
		$finish;
	end

	// output side: random wait per request, plus one long hold when asked
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = calm ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_taken++;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic l);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_msg(input bit closed);
		for (int i = 0; i < msg_q.size(); i++)
			send_item(msg_q[i], closed && (i == msg_q.size() - 1));
		msg_q.delete();
	endtask

	// pending is registered in the checker, hence the first wait
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		drain();
		cfg_valid   <= 1'b1;
		cfg_data[0] <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mode = m;
		mode_writes++;
	endtask

	task automatic load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_q.push_back(s[i]);
	endtask

	task automatic load_raw(input int n);
		repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// well-formed groups, last one optionally padded
	task automatic load_groups(input int groups);
		int pads;
		repeat (4 * groups) msg_q.push_back(ALPHA[8*(63 - $urandom_range(0, 63)) +: 8]);
		pads = $urandom_range(0, 2);
		if (pads >= 1)
			msg_q[msg_q.size() - 1] = PAD_CHAR;
		if (pads == 2)
			msg_q[msg_q.size() - 2] = PAD_CHAR;
	endtask

	initial begin
		int  first_random;
		int  n_msgs;
		bit  pressed;
		pressed = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full group, one- and two-byte flushes
		set_mode(ENCODE);
		msg_q = '{8'h00, 8'hFF, 8'h80};
		send_msg(1);
		msg_q = '{8'hFF};
		send_msg(1);
		msg_q = '{8'h00, 8'h7F};
		send_msg(1);
		// left open, then dropped by the mode write
		msg_q = '{8'hA5, 8'h5A};
		send_msg(0);
		set_mode(DECODE);
		load_text("TWFu");
		send_msg(1);
		load_text("QQ==");
		send_msg(1);
		load_text("+/9z");
		send_msg(1);
		// foreign characters, ending inside a group
		msg_q = '{8'hFF, 8'h80};
		send_msg(1);
		load_text("Q");
		send_msg(1);

		first_random = items_sent;
		while (items_sent < first_random + RANDOM_ITEMS) begin
			set_mode(1'($urandom_range(0, 1)));
			calm = ($urandom_range(0, 3) == 0);
			if (!pressed && items_sent >= first_random + 20) begin
				pressed  = 1'b1;
				calm     = 1'b1;
				hold_req = 1'b1;
			end
			n_msgs = $urandom_range(2, 4);
			repeat (n_msgs) begin
				if (cur_mode == ENCODE)
					load_raw($urandom_range(1, 7));
				else if ($urandom_range(0, 7) == 0)
					load_raw($urandom_range(1, 6));
				else
					load_groups($urandom_range(1, 3));
				send_msg(1);
			end
			if ($urandom_range(0, 3) == 0) begin
				load_raw($urandom_range(1, 3));
				send_msg(0);
			end
			calm = 1'b0;
		end

		drain();
		repeat (12) @(posedge clk);
		$display("covered %0d requests in encode and decode, %0d results, %0d mode writes",
			items_sent, results_taken, mode_writes);
		if (fails == 0 && pending == 0)
			$display("base64_stream_codec_top: match");
		else
			$display("base64_stream_codec_top: mismatch");
		$finish;
	end

endmodule
